FILE: hw/rtl/dda_pkg.sv
`default_nettype none

package dda_pkg;

    localparam int COORD_W            = 6;
    localparam int COORD_SIZE         = 64;
    localparam int DEF_FRACTION_BITS  = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic load_mx;
        logic load_my;
        logic advance;
    } t_step_ctrl;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        r = v;
        if (int'(v) > COORD_SIZE - 1) begin
            r = COORD_W'(COORD_SIZE - 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dda_divider.sv
`default_nettype none

// restoring divider, one quotient bit per cycle: ({dividend, F zeros}) / divisor
module dda_divider #(
    parameter int FRACTION_BITS = dda_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [dda_pkg::COORD_W-1:0]        i_dividend,
    input  wire logic [dda_pkg::COORD_W-1:0]        i_divisor,
    output logic                                    o_done,
    output logic [FRACTION_BITS:0]                  o_quotient
);
    import dda_pkg::*;

    localparam int NB = COORD_W + FRACTION_BITS;
    localparam int CW = $clog2(NB);

    logic [NB-1:0]      r_num;
    logic [COORD_W-1:0] r_rem;
    logic [COORD_W-1:0] r_div;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [COORD_W:0]   rem_sh;
    logic [COORD_W:0]   diff;
    logic               qbit;

    assign rem_sh = {r_rem, r_num[NB-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign qbit   = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NB - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_dividend, {FRACTION_BITS{1'b0}}};
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[NB-2:0], qbit};
            r_rem <= qbit ? diff[COORD_W-1:0] : rem_sh[COORD_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num[FRACTION_BITS:0];

endmodule

`default_nettype wire

FILE: hw/rtl/dda_stepper.sv
`default_nettype none

module dda_stepper #(
    parameter int FRACTION_BITS = dda_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                           i_clk,
    input  wire dda_pkg::t_step_ctrl            i_ctrl,
    input  wire logic [dda_pkg::COORD_W-1:0]    i_sx,
    input  wire logic [dda_pkg::COORD_W-1:0]    i_sy,
    input  wire logic                           i_negx,
    input  wire logic                           i_negy,
    input  wire logic [dda_pkg::COORD_W-1:0]    i_steps,
    input  wire logic [FRACTION_BITS:0]         i_quot,
    output logic [dda_pkg::COORD_W-1:0]         o_point_x,
    output logic [dda_pkg::COORD_W-1:0]         o_point_y,
    output logic                                o_last
);
    import dda_pkg::*;

    localparam int AW = COORD_W + FRACTION_BITS;
    localparam logic [AW-1:0] HALF = AW'(1) << (FRACTION_BITS - 1);

    logic [AW-1:0]          r_ax, r_ay;
    logic [FRACTION_BITS:0] r_mx, r_my;
    logic                   r_negx, r_negy;
    logic [COORD_W-1:0]     r_remain;

    logic [AW-1:0] incx, incy;
    logic [AW-1:0] rx, ry;

    assign incx = {{(AW-FRACTION_BITS-1){1'b0}}, r_mx};
    assign incy = {{(AW-FRACTION_BITS-1){1'b0}}, r_my};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_ax     <= {i_sx, {FRACTION_BITS{1'b0}}};
            r_ay     <= {i_sy, {FRACTION_BITS{1'b0}}};
            r_negx   <= i_negx;
            r_negy   <= i_negy;
            r_remain <= i_steps;
            r_mx     <= '0;
            r_my     <= '0;
        end else begin
            if (i_ctrl.load_mx) begin
                r_mx <= i_quot;
            end
            if (i_ctrl.load_my) begin
                r_my <= i_quot;
            end
            if (i_ctrl.advance) begin
                r_ax     <= r_negx ? r_ax - incx : r_ax + incx;
                r_ay     <= r_negy ? r_ay - incy : r_ay + incy;
                r_remain <= r_remain - 1'b1;
            end
        end
    end

    // round half up
    assign rx        = r_ax + HALF;
    assign ry        = r_ay + HALF;
    assign o_point_x = rx[AW-1 -: COORD_W];
    assign o_point_y = ry[AW-1 -: COORD_W];
    assign o_last    = (r_remain == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/dda_line_rasterizer.sv
`default_nettype none

// DDA line rasterizer.
// Input channel (i_in_valid / o_in_ready): one segment per transaction,
// start and end pixel coordinates; values above COORD_SIZE-1 saturate.
// Output channel (o_out_valid / i_out_ready): steps+1 points per segment,
// steps = max(|dx|, |dy|), the final point flagged by o_last_point.
// One segment at a time: o_in_ready is high only while idle.
// The x and y increments come from one shared restoring divider, x first
// and then y, and the first point shows once both divisions are done. A
// zero-length segment skips the divider and shows its single point on the
// next cycle. Points then leave at one per cycle while i_out_ready is high;
// a stall holds the current point and the accumulators. After the last
// point the block is ready again on the next cycle. Synchronous reset
// returns the block to idle and drops any segment.
module dda_line_rasterizer #(
    parameter int FRACTION_BITS = dda_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [dda_pkg::COORD_W-1:0]    i_start_x,
    input  wire logic [dda_pkg::COORD_W-1:0]    i_start_y,
    input  wire logic [dda_pkg::COORD_W-1:0]    i_end_x,
    input  wire logic [dda_pkg::COORD_W-1:0]    i_end_y,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [dda_pkg::COORD_W-1:0]         o_point_x,
    output logic [dda_pkg::COORD_W-1:0]         o_point_y,
    output logic                                o_last_point
);
    import dda_pkg::*;

    t_state r_state, n_state;

    logic [COORD_W-1:0] r_ady, r_steps;

    logic [COORD_W-1:0] sx, sy, ex, ey;
    logic               negx, negy;
    logic [COORD_W-1:0] adx, ady, steps;

    t_step_ctrl             ctrl;
    logic                   div_start;
    logic                   div_done;
    logic [COORD_W-1:0]     div_dividend, div_divisor;
    logic [FRACTION_BITS:0] quot;
    logic                   last;
    logic                   in_xact;

    assign sx    = clamp_coord(i_start_x);
    assign sy    = clamp_coord(i_start_y);
    assign ex    = clamp_coord(i_end_x);
    assign ey    = clamp_coord(i_end_y);
    assign negx  = (ex < sx);
    assign negy  = (ey < sy);
    assign adx   = negx ? sx - ex : ex - sx;
    assign ady   = negy ? sy - ey : ey - sy;
    assign steps = (adx > ady) ? adx : ady;

    assign in_xact = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_ady   <= ady;
            r_steps <= steps;
        end
    end

    always_comb begin
        n_state   = r_state;
        ctrl      = '0;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xact) begin
                    ctrl.load = 1'b1;
                    if (steps == '0) begin
                        n_state = ST_EMIT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIVX;
                    end
                end
            end
            ST_DIVX: begin
                if (div_done) begin
                    ctrl.load_mx = 1'b1;
                    div_start    = 1'b1;
                    n_state      = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (div_done) begin
                    ctrl.load_my = 1'b1;
                    n_state      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    if (last) begin
                        n_state = ST_IDLE;
                    end else begin
                        ctrl.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign div_dividend = (r_state == ST_IDLE) ? adx   : r_ady;
    assign div_divisor  = (r_state == ST_IDLE) ? steps : r_steps;

    dda_divider #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    dda_stepper #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_step (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_sx      (sx),
        .i_sy      (sy),
        .i_negx    (negx),
        .i_negy    (negy),
        .i_steps   (steps),
        .i_quot    (quot),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_last    (last)
    );

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = (r_state == ST_EMIT);
    assign o_last_point = last;

endmodule

`default_nettype wire

FILE: hw/rtl/dda_checker.sv
`default_nettype none

module dda_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [dda_pkg::COORD_W-1:0] o_point_x,
    input wire logic [dda_pkg::COORD_W-1:0] o_point_y,
    input wire logic                        o_last_point
);

    // one segment in flight: never ready while points are pending
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output valid");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after input transaction");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_point) |=> (!o_out_valid && o_in_ready))
        else $error("segment did not end after last point");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_point_x) && $stable(o_point_y)
             && $stable(o_last_point)))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (o_in_ready && !o_out_valid))
        else $error("not idle after reset");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);

`default_nettype wire

FILE: tb/dda_point_checker.sv
module dda_point_checker #(
    parameter int FRACTION_BITS = dda_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [dda_pkg::COORD_W-1:0] i_start_x,
    input  wire logic [dda_pkg::COORD_W-1:0] i_start_y,
    input  wire logic [dda_pkg::COORD_W-1:0] i_end_x,
    input  wire logic [dda_pkg::COORD_W-1:0] i_end_y,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [dda_pkg::COORD_W-1:0] i_point_x,
    input  wire logic [dda_pkg::COORD_W-1:0] i_point_y,
    input  wire logic                        i_last_point,
    output int                               o_mismatches,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = dda_pkg::COORD_W;
    localparam int ACC_W   = FRACTION_BITS + COORD_W + 2;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [ACC_W-1:0]   t_acc;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_point;

    t_point expected_points[$];
    t_point want;
    int     mismatch_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = expected_points.size();

    function automatic t_coord saturate_coord(input t_coord v);
        if (int'(v) > dda_pkg::COORD_SIZE - 1) begin
            return t_coord'(dda_pkg::COORD_SIZE - 1);
        end
        return v;
    endfunction

    function automatic t_coord round_to_pixel(input t_acc acc);
        t_acc sum;
        sum = acc + (t_acc'(1) << (FRACTION_BITS - 1));
        return t_coord'(sum >> FRACTION_BITS);
    endfunction

    function automatic void rasterize_segment(input t_coord sx_in, input t_coord sy_in,
                                              input t_coord ex_in, input t_coord ey_in);
        t_coord sx, sy, ex, ey;
        logic   negx, negy;
        t_coord adx, ady, steps;
        t_acc   incx, incy, accx, accy;
        t_point pt;
        int     i;
        sx    = saturate_coord(sx_in);
        sy    = saturate_coord(sy_in);
        ex    = saturate_coord(ex_in);
        ey    = saturate_coord(ey_in);
        negx  = ex < sx;
        negy  = ey < sy;
        adx   = negx ? sx - ex : ex - sx;
        ady   = negy ? sy - ey : ey - sy;
        steps = (adx > ady) ? adx : ady;
        if (steps == '0) begin
            pt.x    = sx;
            pt.y    = sy;
            pt.last = 1'b1;
            expected_points.push_back(pt);
            return;
        end
        incx = (t_acc'(adx) << FRACTION_BITS) / t_acc'(steps);
        incy = (t_acc'(ady) << FRACTION_BITS) / t_acc'(steps);
        accx = t_acc'(sx) << FRACTION_BITS;
        accy = t_acc'(sy) << FRACTION_BITS;
        for (i = 0; i <= int'(steps); i++) begin
            pt.x    = round_to_pixel(accx);
            pt.y    = round_to_pixel(accy);
            pt.last = (i == int'(steps));
            expected_points.push_back(pt);
            accx = negx ? accx - incx : accx + incx;
            accy = negy ? accy - incy : accy + incy;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_points.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: unexpected point x=%0d y=%0d last=%0b", $realtime,
                                 i_point_x, i_point_y, i_last_point);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (i_point_x !== want.x || i_point_y !== want.y
                            || i_last_point !== want.last) begin
                        if (mismatch_count < 10) begin
                            $display({"%0t: point mismatch: expected x=%0d y=%0d last=%0b,",
                                      " got x=%0d y=%0d last=%0b"},
                                     $realtime, want.x, want.y, want.last,
                                     i_point_x, i_point_y, i_last_point);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                rasterize_segment(i_start_x, i_start_y, i_end_x, i_end_y);
            end
        end
    end

endmodule

FILE: tb/dda_line_rasterizer_tb.sv
module dda_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W       = dda_pkg::COORD_W;
    localparam int MAX_COORD     = dda_pkg::COORD_SIZE - 1;
    localparam int RANDOM_COUNT  = 400;
    localparam int DRAIN_CYCLES  = 80;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DIRECTED_LEN  = 22;

    typedef logic [COORD_W-1:0] t_coord;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    t_coord start_x = '0;
    t_coord start_y = '0;
    t_coord end_x = '0;
    t_coord end_y = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    t_coord point_x;
    t_coord point_y;
    logic   last_point;

    int     mismatches;
    int     pending;
    int     segments_sent = 0;
    int     cycle_count = 0;
    logic   in_burst = 1'b0;
    logic   out_burst = 1'b0;
    logic   out_hold = 1'b0;
    int     ready_gap = 0;
    int     rx_draw;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    dda_line_rasterizer i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_start_x    (start_x),
        .i_start_y    (start_y),
        .i_end_x      (end_x),
        .i_end_y      (end_y),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_point_x    (point_x),
        .o_point_y    (point_y),
        .o_last_point (last_point)
    );

    dda_point_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_start_x    (start_x),
        .i_start_y    (start_y),
        .i_end_x      (end_x),
        .i_end_y      (end_y),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_point_x    (point_x),
        .i_point_y    (point_y),
        .i_last_point (last_point),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // point sink: random gap after each transaction, bursts with no gap
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            ready_gap <= 0;
        end else if (out_hold) begin
            out_ready <= 1'b0;
        end else if (out_valid && out_ready) begin
            rx_draw = out_burst ? 0 : $urandom_range(0, 18);
            if (rx_draw == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                ready_gap <= rx_draw - 1;
            end
            if ($urandom_range(0, 59) == 0) begin
                out_burst <= ~out_burst;
            end
        end else if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // long sink stall while a full diagonal is in flight
    initial begin
        wait (segments_sent >= 4);
        @(posedge clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
    end

    task automatic offer_segment(input t_coord sx, input t_coord sy,
                                 input t_coord ex, input t_coord ey);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        segments_sent++;
        if ($urandom_range(0, 39) == 0) begin
            in_burst = ~in_burst;
        end
    endtask

    function automatic t_coord near_coord(input t_coord c);
        int lo, hi;
        lo = (int'(c) > 4) ? int'(c) - 4 : 0;
        hi = (int'(c) < MAX_COORD - 4) ? int'(c) + 4 : MAX_COORD;
        return t_coord'($urandom_range(lo, hi));
    endfunction

    initial begin
        t_coord directed[DIRECTED_LEN][4];
        t_coord sx, sy, ex, ey;
        int     kind;
        int     n;
        directed = '{
            '{0, 0, 0, 0},     '{63, 63, 63, 63}, '{21, 42, 21, 42},
            '{0, 0, 63, 63},   '{63, 63, 0, 0},   '{0, 63, 63, 0},
            '{63, 0, 0, 63},   '{0, 10, 63, 10},  '{63, 10, 0, 10},
            '{5, 0, 5, 63},    '{5, 63, 5, 0},    '{0, 0, 63, 1},
            '{0, 0, 1, 63},    '{10, 10, 11, 10}, '{10, 10, 10, 9},
            '{0, 0, 63, 32},   '{63, 0, 0, 21},   '{32, 32, 33, 34},
            '{42, 21, 21, 0},  '{1, 62, 62, 1},   '{0, 0, 2, 1},
            '{3, 3, 1, 2}
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED_LEN; n++) begin
            offer_segment(directed[n][0], directed[n][1], directed[n][2], directed[n][3]);
        end

        for (n = 0; n < RANDOM_COUNT; n++) begin
            kind = $urandom_range(0, 99);
            sx = t_coord'($urandom_range(0, MAX_COORD));
            sy = t_coord'($urandom_range(0, MAX_COORD));
            if (kind < 60) begin
                ex = t_coord'($urandom_range(0, MAX_COORD));
                ey = t_coord'($urandom_range(0, MAX_COORD));
            end else if (kind < 85) begin
                ex = near_coord(sx);
                ey = near_coord(sy);
            end else if (kind < 95) begin
                ex = sx;
                ey = sy;
            end else begin
                ex = $urandom_range(0, 1) ? sx : t_coord'($urandom_range(0, MAX_COORD));
                ey = $urandom_range(0, 1) ? sy : t_coord'($urandom_range(0, MAX_COORD));
            end
            offer_segment(sx, sy, ex, ey);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dda_pkg.sv
hw/rtl/dda_divider.sv
hw/rtl/dda_stepper.sv
hw/rtl/dda_line_rasterizer.sv
hw/rtl/dda_checker.sv
tb/dda_point_checker.sv
tb/dda_line_rasterizer_tb.sv
